// ===== hw/rtl/running_median_two_heaps_top_defines.svh =====
// Assertion macros shared by the running median RTL.
`ifndef RUNNING_MEDIAN_TWO_HEAPS_TOP_DEFINES_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define RMH_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define RMH_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define RMH_ASSERT(label, clk, rst_n, prop)
`define RMH_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== hw/rtl/rmh_pkg.sv =====
// Package with constants and types for the running median block.
package rmh_pkg;
    localparam int CAPACITY   = 1023;
    localparam int HEAP_DEPTH = CAPACITY / 2 + 1;
    localparam int AW         = $clog2(HEAP_DEPTH);
    localparam int CW         = $clog2(HEAP_DEPTH + 1);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHOOSE_RD,
        ST_CHOOSE,
        ST_PUSH_WR,
        ST_UP_RD,
        ST_UP_CMP,
        ST_BAL,
        ST_POP_RD0,
        ST_POP_RD1,
        ST_POP_WR0,
        ST_DN_RDL,
        ST_DN_RDR,
        ST_DN_CMP,
        ST_MED_RD,
        ST_MED_SUM,
        ST_OUT
    } state_t;
endpackage

// ===== hw/rtl/running_median_two_heaps_top.sv =====
// Running median block: two heaps in memory driven by a single sequencer.
//
// Input channel: sample_value with in_valid/in_stall. Output channel:
// median_doubled and dropped with out_valid/out_stall; one result beat per
// input beat, in order. median_doubled is twice the median of all stored
// values, so half values stay exact; dropped is set when the store was full
// and the sample was not kept.
// Each beat is handled by one sequencer that walks heap memories with a
// shared signed comparator for the sifts, one memory access per cycle. A
// dropped beat goes straight to the median read; a stored beat is pushed
// and sifted up, and when the heap sizes differ by more than one the top of
// the larger heap is popped, sifted down and pushed across. Each heap holds
// 512 entries in a memory with a single port. in_stall is high while a
// beat is being worked on or while a result waits in the output register.
// If the receiver stalls, the result is held unchanged and no new beat is
// taken. Reset empties both heaps by clearing the counts only; the memories
// need no clearing pass.
`include "running_median_two_heaps_top_defines.svh"
module running_median_two_heaps_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] sample_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [32:0] median_doubled,
    output logic               dropped
);
    localparam int AW = rmh_pkg::AW;
    localparam int CW = rmh_pkg::CW;

    logic signed [31:0] lo_mem [rmh_pkg::HEAP_DEPTH];
    logic signed [31:0] hi_mem [rmh_pkg::HEAP_DEPTH];

    rmh_pkg::state_t state_reg, state_next;
    logic [CW-1:0] lo_cnt_reg, lo_cnt_next, hi_cnt_reg, hi_cnt_next;
    logic signed [31:0] val_reg, val_next;     // value being sifted
    logic signed [31:0] a_reg, a_next;         // scratch operand
    logic [AW-1:0] k_reg, k_next, best_reg, best_next;
    logic side_reg, side_next;                 // 1: lower (max) heap
    logic bal_reg, bal_next;                   // push is the balancing move
    logic ov_reg, ov_next;
    logic drop_reg, drop_next;
    logic signed [32:0] med_reg, med_next;

    // memory port controls
    logic              lo_we, hi_we;
    logic [AW-1:0]     lo_addr, hi_addr;
    logic signed [31:0] wdata;
    logic signed [31:0] lo_q, hi_q;

    always_ff @(posedge clk)
    begin
        if (lo_we)
        begin
            lo_mem[lo_addr] <= wdata;
        end
        lo_q <= lo_mem[lo_addr];
    end

    always_ff @(posedge clk)
    begin
        if (hi_we)
        begin
            hi_mem[hi_addr] <= wdata;
        end
        hi_q <= hi_mem[hi_addr];
    end

    // shared comparator: does x rank above y in the heap on this side
    logic signed [31:0] cmp_x, cmp_y;
    logic cmp_above;
    assign cmp_above = side_reg ? (cmp_x > cmp_y) : (cmp_x < cmp_y);

    logic signed [31:0] rd_q;
    assign rd_q = side_reg ? lo_q : hi_q;

    logic [CW-1:0] cur_cnt;
    assign cur_cnt = side_reg ? lo_cnt_reg : hi_cnt_reg;

    logic [CW:0] lidx, ridx;
    assign lidx = (CW+1)'({k_reg, 1'b1});
    assign ridx = (CW+1)'({k_reg, 1'b0}) + (CW+1)'(2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rmh_pkg::ST_IDLE;
            lo_cnt_reg <= '0;
            hi_cnt_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            lo_cnt_reg <= lo_cnt_next;
            hi_cnt_reg <= hi_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        a_reg    <= a_next;
        k_reg    <= k_next;
        best_reg <= best_next;
        side_reg <= side_next;
        bal_reg  <= bal_next;
        ov_reg   <= ov_next;
        drop_reg <= drop_next;
        med_reg  <= med_next;
    end

    assign in_stall       = (state_reg != rmh_pkg::ST_IDLE);
    assign out_valid      = (state_reg == rmh_pkg::ST_OUT);
    assign median_doubled = med_reg;
    assign dropped        = drop_reg;

    always_comb
    begin
        state_next  = state_reg;
        lo_cnt_next = lo_cnt_reg;
        hi_cnt_next = hi_cnt_reg;
        val_next    = val_reg;
        a_next      = a_reg;
        k_next      = k_reg;
        best_next   = best_reg;
        side_next   = side_reg;
        bal_next    = bal_reg;
        ov_next     = ov_reg;
        drop_next   = drop_reg;
        med_next    = med_reg;
        lo_we       = 1'b0;
        hi_we       = 1'b0;
        lo_addr     = '0;
        hi_addr     = '0;
        wdata       = val_reg;
        cmp_x       = val_reg;
        cmp_y       = rd_q;
        case (state_reg)
            rmh_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    val_next  = sample_value;
                    bal_next  = 1'b0;
                    ov_next   = 1'b0;
                    drop_next = (CW+1)'(lo_cnt_reg) + (CW+1)'(hi_cnt_reg)
                                >= (CW+1)'(rmh_pkg::CAPACITY);
                    if ((CW+1)'(lo_cnt_reg) + (CW+1)'(hi_cnt_reg)
                        >= (CW+1)'(rmh_pkg::CAPACITY))
                    begin
                        state_next = rmh_pkg::ST_MED_RD;
                    end
                    else
                    begin
                        state_next = rmh_pkg::ST_CHOOSE_RD;
                    end
                end
            end
            rmh_pkg::ST_CHOOSE_RD:
            begin
                // tops are read at address zero by default
                state_next = rmh_pkg::ST_CHOOSE;
            end
            rmh_pkg::ST_CHOOSE:
            begin
                if (hi_cnt_reg == '0)
                begin
                    side_next = 1'b1;
                end
                else if (lo_cnt_reg != '0 && val_reg < lo_q)
                begin
                    side_next = 1'b1;
                end
                else if (lo_cnt_reg == '0 || val_reg > hi_q)
                begin
                    side_next = 1'b0;
                end
                else
                begin
                    side_next = 1'b1;
                end
                state_next = rmh_pkg::ST_PUSH_WR;
            end
            rmh_pkg::ST_PUSH_WR:
            begin
                if (cur_cnt >= CW'(rmh_pkg::HEAP_DEPTH))
                begin
                    state_next = bal_reg ? rmh_pkg::ST_MED_RD : rmh_pkg::ST_BAL;
                end
                else
                begin
                    k_next = cur_cnt[AW-1:0];
                    if (side_reg)
                    begin
                        lo_we       = 1'b1;
                        lo_addr     = cur_cnt[AW-1:0];
                        lo_cnt_next = lo_cnt_reg + CW'(1);
                    end
                    else
                    begin
                        hi_we       = 1'b1;
                        hi_addr     = cur_cnt[AW-1:0];
                        hi_cnt_next = hi_cnt_reg + CW'(1);
                    end
                    state_next = rmh_pkg::ST_UP_RD;
                end
            end
            rmh_pkg::ST_UP_RD:
            begin
                if (k_reg == '0)
                begin
                    state_next = bal_reg ? rmh_pkg::ST_MED_RD : rmh_pkg::ST_BAL;
                end
                else
                begin
                    lo_addr    = AW'((k_reg - AW'(1)) >> 1);
                    hi_addr    = lo_addr;
                    state_next = rmh_pkg::ST_UP_CMP;
                end
            end
            rmh_pkg::ST_UP_CMP:
            begin
                // val sits at k; swap it with the parent if it ranks above
                lo_addr = AW'((k_reg - AW'(1)) >> 1);
                hi_addr = lo_addr;
                if (cmp_above)
                begin
                    wdata = rd_q;
                    lo_addr = k_reg;
                    hi_addr = k_reg;
                    lo_we = side_reg;
                    hi_we = !side_reg;
                    k_next = AW'((k_reg - AW'(1)) >> 1);
                    a_next = val_reg;
                    state_next = rmh_pkg::ST_POP_WR0;
                    best_next = AW'((k_reg - AW'(1)) >> 1);
                end
                else
                begin
                    state_next = bal_reg ? rmh_pkg::ST_MED_RD : rmh_pkg::ST_BAL;
                end
            end
            rmh_pkg::ST_POP_WR0:
            begin
                // finish a swap: write the sifted value at best, continue
                lo_addr = best_reg;
                hi_addr = best_reg;
                lo_we   = side_reg;
                hi_we   = !side_reg;
                wdata   = val_reg;
                k_next  = best_reg;
                state_next = ov_reg ? rmh_pkg::ST_DN_RDL : rmh_pkg::ST_UP_RD;
            end
            rmh_pkg::ST_BAL:
            begin
                ov_next = 1'b0;
                if (lo_cnt_reg > hi_cnt_reg + CW'(1))
                begin
                    side_next  = 1'b1;
                    state_next = rmh_pkg::ST_POP_RD0;
                end
                else if (hi_cnt_reg > lo_cnt_reg + CW'(1))
                begin
                    side_next  = 1'b0;
                    state_next = rmh_pkg::ST_POP_RD0;
                end
                else
                begin
                    state_next = rmh_pkg::ST_MED_RD;
                end
            end
            rmh_pkg::ST_POP_RD0:
            begin
                // read the top, remove one entry
                state_next = rmh_pkg::ST_POP_RD1;
                if (side_reg)
                begin
                    lo_cnt_next = lo_cnt_reg - CW'(1);
                end
                else
                begin
                    hi_cnt_next = hi_cnt_reg - CW'(1);
                end
            end
            rmh_pkg::ST_POP_RD1:
            begin
                a_next  = rd_q;  // popped top, pushed across later
                lo_addr = cur_cnt[AW-1:0];
                hi_addr = cur_cnt[AW-1:0];
                state_next = rmh_pkg::ST_DN_RDL;
                ov_next = 1'b1;
                k_next  = '0;
                bal_next = 1'b1;
            end
            rmh_pkg::ST_DN_RDL:
            begin
                // Only the first visit after a pop is at the root; the last entry
                // arrives then as the new value.
                if (k_reg == '0)
                begin
                    val_next = rd_q;
                end
                if (lidx < (CW+1)'(cur_cnt))
                begin
                    lo_addr    = lidx[AW-1:0];
                    hi_addr    = lidx[AW-1:0];
                    state_next = rmh_pkg::ST_DN_RDR;
                end
                else
                begin
                    state_next = rmh_pkg::ST_DN_CMP;
                end
                best_next = k_reg;
            end
            rmh_pkg::ST_DN_RDR:
            begin
                lo_addr = ridx[AW-1:0];
                hi_addr = ridx[AW-1:0];
                // left child data arrives now
                cmp_x = rd_q;
                cmp_y = val_reg;
                if (cmp_above)
                begin
                    best_next = lidx[AW-1:0];
                    med_next  = {rd_q[31], rd_q};
                end
                else
                begin
                    med_next = {val_reg[31], val_reg};
                end
                state_next = rmh_pkg::ST_DN_CMP;
            end
            rmh_pkg::ST_DN_CMP:
            begin
                if (best_reg != k_reg || lidx < (CW+1)'(cur_cnt))
                begin
                    if (ridx < (CW+1)'(cur_cnt))
                    begin
                        cmp_x = rd_q;
                        cmp_y = med_reg[31:0];
                    end
                    else
                    begin
                        cmp_x = med_reg[31:0];
                        cmp_y = med_reg[31:0];
                    end
                end
                else
                begin
                    cmp_x = val_reg;
                    cmp_y = val_reg;
                end
                if (ridx < (CW+1)'(cur_cnt) && cmp_above)
                begin
                    // right child wins: move it up to k
                    wdata   = rd_q;
                    lo_addr = k_reg;
                    hi_addr = k_reg;
                    lo_we   = side_reg;
                    hi_we   = !side_reg;
                    best_next  = ridx[AW-1:0];
                    state_next = rmh_pkg::ST_POP_WR0;
                end
                else if (best_reg != k_reg)
                begin
                    wdata   = med_reg[31:0];
                    lo_addr = k_reg;
                    hi_addr = k_reg;
                    lo_we   = side_reg;
                    hi_we   = !side_reg;
                    state_next = rmh_pkg::ST_POP_WR0;
                end
                else
                begin
                    // settled: write value at k, then push popped top across
                    wdata   = val_reg;
                    lo_addr = k_reg;
                    hi_addr = k_reg;
                    lo_we   = side_reg && (cur_cnt != '0);
                    hi_we   = !side_reg && (cur_cnt != '0);
                    val_next  = a_reg;
                    side_next = !side_reg;
                    ov_next   = 1'b0;
                    state_next = rmh_pkg::ST_PUSH_WR;
                end
            end
            rmh_pkg::ST_MED_RD:
            begin
                state_next = rmh_pkg::ST_MED_SUM;
            end
            rmh_pkg::ST_MED_SUM:
            begin
                if (lo_cnt_reg == hi_cnt_reg)
                begin
                    med_next = (lo_cnt_reg == '0) ? '0
                             : (33'(lo_q) + 33'(hi_q));
                end
                else if (lo_cnt_reg > hi_cnt_reg)
                begin
                    med_next = {lo_q, 1'b0};
                end
                else
                begin
                    med_next = {hi_q, 1'b0};
                end
                state_next = rmh_pkg::ST_OUT;
            end
            rmh_pkg::ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = rmh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rmh_pkg::ST_IDLE;
            end
        endcase
    end

    `RMH_ASSERT(a_in_out_excl, clk, rst_n, !(out_valid && !in_stall))
    `RMH_ASSERT(a_hold_out, clk, rst_n, (out_valid && out_stall) |=> $stable(median_doubled))
    `RMH_ASSERT(a_cnt_bal, clk, rst_n,
        (state_reg == rmh_pkg::ST_OUT) |->
        ((lo_cnt_reg <= hi_cnt_reg + CW'(1)) && (hi_cnt_reg <= lo_cnt_reg + CW'(1))))
endmodule
